>>> rtl/llrm_pkg.sv
package llrm_pkg;

   // Sizing
   localparam int HEAP_CELLS     = 1024;
   localparam int REGISTER_COUNT = 10;
   localparam int HEAP_AW        = $clog2(HEAP_CELLS);
   localparam int FP_W           = $clog2(HEAP_CELLS + 1);
   localparam int REG_AW         = $clog2(REGISTER_COUNT);

   // Field widths fixed by the item format
   localparam int KIND_W   = 3;
   localparam int REG_IDX_W = 4;
   localparam int HANDLE_W = 16;
   localparam int STATUS_W = 2;

   localparam logic [HANDLE_W-1:0] CELL_BASE = 16'h8000;
   localparam logic [HANDLE_W-1:0] NIL       = 16'h0000;

   // Instruction kinds
   localparam logic [KIND_W-1:0] KIND_SWAP   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ASSIGN = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CAR    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CDR    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CONS   = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOT_CONS = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;

   // Register write selection
   typedef enum logic [2:0] {
      WS_A_VB,
      WS_B_VA,
      WS_A_SYM,
      WS_A_HEAP,
      WS_B_CELL,
      WS_A_NIL
   } wsel_type;

   typedef struct packed {
      logic     ready;
      logic     load;
      logic     capture;
      logic     reg_we;
      wsel_type wsel;
      logic     car_we;
      logic     cdr_we;
      logic     heap_cons;
      logic     fp_inc;
      logic     out_load;
   } cmd_type;

   typedef struct packed {
      logic                req_valid;
      logic                out_busy;
      logic [KIND_W-1:0]   kind;
      logic [STATUS_W-1:0] status;
   } stat_type;

endpackage

>>> rtl/llrm_ifs.sv
interface llrm_req_if import llrm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [REG_IDX_W-1:0] first_reg;
   logic [REG_IDX_W-1:0] second_reg;
   logic [HANDLE_W-1:0]  symbol_value;

   modport source (output valid, kind, first_reg, second_reg, symbol_value, input ready);
   modport sink   (input valid, kind, first_reg, second_reg, symbol_value, output ready);
endinterface

interface llrm_rsp_if import llrm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [HANDLE_W-1:0] first_value;
   logic [HANDLE_W-1:0] second_value;
   logic [STATUS_W-1:0] status;

   modport source (output valid, first_value, second_value, status, input ready);
   modport sink   (input valid, first_value, second_value, status, output ready);
endinterface

>>> rtl/llrm_ram.sv
module llrm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

>>> rtl/llrm_datapath.sv
module llrm_datapath import llrm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   llrm_req_if.sink     req_chan,
   llrm_rsp_if.source   rsp_chan,
   input  cmd_type      cmd,
   output stat_type     stat
);

   // Latched item
   logic [KIND_W-1:0]    kind_ff;
   logic [REG_IDX_W-1:0] a_ff, b_ff;
   logic [HANDLE_W-1:0]  sym_ff;
   logic                 a_vld_ff, b_vld_ff, a_vld_in, b_vld_in;

   // Operand values and tracked final values
   logic [HANDLE_W-1:0]  va_ff, vb_ff, fa_ff, fb_ff, fa_in, fb_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [HEAP_AW-1:0]   cell_idx_ff;
   logic [FP_W-1:0]      fp_ff, fp_in;
   logic                 reg_vld_ff [REGISTER_COUNT];

   // Memory ports
   logic [HANDLE_W-1:0]  rd_a, rd_b, ram_a_rd, ram_b_rd, car_rd, cdr_rd;
   logic [REG_IDX_W-1:0] waddr;
   logic [HANDLE_W-1:0]  wdata;
   logic                 wr_en;
   logic [HEAP_AW-1:0]   heap_addr;
   logic [HANDLE_W-1:0]  cdr_wdata;
   logic                 cell_ok;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_W-1:0]  out_a_ff, out_b_ff;
   logic [STATUS_W-1:0]  out_st_ff;

   assign req_chan.ready = cmd.ready;
   assign stat.req_valid = req_chan.valid;
   assign stat.out_busy  = rsp_valid_ff && !rsp_chan.ready;
   assign stat.kind      = kind_ff;
   assign stat.status    = status_ff;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.first_value  = out_a_ff;
   assign rsp_chan.second_value = out_b_ff;
   assign rsp_chan.status       = out_st_ff;

   // Registers never written, or outside the file, read as nil
   always_comb begin
      a_vld_in = 1'b0;
      b_vld_in = 1'b0;
      if ({1'b0, req_chan.first_reg} < (REG_IDX_W + 1)'(REGISTER_COUNT)) begin
         a_vld_in = reg_vld_ff[req_chan.first_reg[REG_AW-1:0]];
      end
      if ({1'b0, req_chan.second_reg} < (REG_IDX_W + 1)'(REGISTER_COUNT)) begin
         b_vld_in = reg_vld_ff[req_chan.second_reg[REG_AW-1:0]];
      end
   end

   assign rd_a = a_vld_ff ? ram_a_rd : NIL;
   assign rd_b = b_vld_ff ? ram_b_rd : NIL;

   assign cell_ok = rd_b[HANDLE_W-1] &&
                    ({1'b0, rd_b[HANDLE_W-2:0]} < HANDLE_W'(fp_ff));

   always_comb begin
      status_in = STAT_OK;
      case (kind_ff)
         KIND_CAR, KIND_CDR: begin
            if (!cell_ok) begin
               status_in = STAT_NOT_CONS;
            end
         end
         KIND_CONS: begin
            if (fp_ff == FP_W'(HEAP_CELLS)) begin
               status_in = STAT_FULL;
            end
         end
         default: status_in = STAT_OK;
      endcase
   end

   // Register write slot
   always_comb begin
      case (cmd.wsel)
         WS_A_VB:   begin waddr = a_ff; wdata = vb_ff; end
         WS_B_VA:   begin waddr = b_ff; wdata = va_ff; end
         WS_A_SYM:  begin waddr = a_ff; wdata = sym_ff; end
         WS_A_HEAP: begin waddr = a_ff; wdata = (kind_ff == KIND_CAR) ? car_rd : cdr_rd; end
         WS_B_CELL: begin waddr = b_ff; wdata = CELL_BASE | HANDLE_W'(fp_ff); end
         WS_A_NIL:  begin waddr = a_ff; wdata = NIL; end
         default:   begin waddr = a_ff; wdata = NIL; end
      endcase
   end

   assign wr_en = cmd.reg_we && ({1'b0, waddr} < (REG_IDX_W + 1)'(REGISTER_COUNT));

   always_comb begin
      fa_in = fa_ff;
      fb_in = fb_ff;
      if (cmd.capture) begin
         fa_in = rd_a;
         fb_in = rd_b;
      end else if (wr_en) begin
         if (waddr == a_ff) begin
            fa_in = wdata;
         end
         if (waddr == b_ff) begin
            fb_in = wdata;
         end
      end
   end

   assign heap_addr = cmd.heap_cons ? fp_ff[HEAP_AW-1:0] : cell_idx_ff;
   assign cdr_wdata = cmd.heap_cons ? vb_ff : va_ff;
   assign fp_in     = cmd.fp_inc ? fp_ff + FP_W'(1) : fp_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < REGISTER_COUNT; i++) begin
            reg_vld_ff[i] <= 1'b0;
         end
      end else begin
         fp_ff        <= fp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            reg_vld_ff[waddr[REG_AW-1:0]] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_chan.kind;
         a_ff     <= req_chan.first_reg;
         b_ff     <= req_chan.second_reg;
         sym_ff   <= req_chan.symbol_value;
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
      end
      if (cmd.capture) begin
         va_ff       <= rd_a;
         vb_ff       <= rd_b;
         status_ff   <= status_in;
         cell_idx_ff <= rd_b[HEAP_AW-1:0];
      end
      fa_ff <= fa_in;
      fb_ff <= fb_in;
      if (cmd.out_load) begin
         out_a_ff  <= fa_ff;
         out_b_ff  <= fb_ff;
         out_st_ff <= status_ff;
      end
   end

   // Two copies of the register file give two read ports
   llrm_ram #(.WIDTH(HANDLE_W), .DEPTH(REGISTER_COUNT)) u_reg_a (
      .clock (clock),
      .we    (wr_en),
      .waddr (waddr[REG_AW-1:0]),
      .wdata (wdata),
      .raddr (req_chan.first_reg[REG_AW-1:0]),
      .rdata (ram_a_rd)
   );

   llrm_ram #(.WIDTH(HANDLE_W), .DEPTH(REGISTER_COUNT)) u_reg_b (
      .clock (clock),
      .we    (wr_en),
      .waddr (waddr[REG_AW-1:0]),
      .wdata (wdata),
      .raddr (req_chan.second_reg[REG_AW-1:0]),
      .rdata (ram_b_rd)
   );

   llrm_ram #(.WIDTH(HANDLE_W), .DEPTH(HEAP_CELLS)) u_heap_car (
      .clock (clock),
      .we    (cmd.car_we),
      .waddr (heap_addr),
      .wdata (va_ff),
      .raddr (rd_b[HEAP_AW-1:0]),
      .rdata (car_rd)
   );

   llrm_ram #(.WIDTH(HANDLE_W), .DEPTH(HEAP_CELLS)) u_heap_cdr (
      .clock (clock),
      .we    (cmd.cdr_we),
      .waddr (heap_addr),
      .wdata (cdr_wdata),
      .raddr (rd_b[HEAP_AW-1:0]),
      .rdata (cdr_rd)
   );

endmodule

>>> rtl/llrm_ctrl.sv
module llrm_ctrl import llrm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CAPT = 5'b00010,
      ST_OP   = 5'b00100,
      ST_WR2  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      cmd.wsel = WS_A_NIL;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.ready = 1'b1;
            cmd.load  = stat.req_valid;
            if (stat.req_valid) begin
               state_in = ST_CAPT;
            end
         end
         ST_CAPT: begin
            cmd.capture = 1'b1;
            state_in    = ST_OP;
         end
         ST_OP: begin
            state_in = ST_DONE;
            case (stat.kind)
               KIND_SWAP: begin
                  cmd.reg_we = 1'b1;
                  cmd.wsel   = WS_A_VB;
                  state_in   = ST_WR2;
               end
               KIND_ASSIGN: begin
                  cmd.reg_we = 1'b1;
                  cmd.wsel   = WS_A_SYM;
               end
               KIND_CAR, KIND_CDR: begin
                  if (stat.status == STAT_OK) begin
                     cmd.reg_we = 1'b1;
                     cmd.wsel   = WS_A_HEAP;
                     cmd.car_we = (stat.kind == KIND_CAR);
                     cmd.cdr_we = (stat.kind == KIND_CDR);
                  end
               end
               KIND_CONS: begin
                  if (stat.status == STAT_OK) begin
                     cmd.reg_we    = 1'b1;
                     cmd.wsel      = WS_B_CELL;
                     cmd.car_we    = 1'b1;
                     cmd.cdr_we    = 1'b1;
                     cmd.heap_cons = 1'b1;
                     cmd.fp_inc    = 1'b1;
                     state_in      = ST_WR2;
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_WR2: begin
            cmd.reg_we = 1'b1;
            cmd.wsel   = (stat.kind == KIND_SWAP) ? WS_B_VA : WS_A_NIL;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!stat.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/linear_lisp_register_machine_top.sv
// Linear-Lisp register machine: executes one instruction per request item.
// Channels: req_chan carries an instruction item (kind, first_reg, second_reg,
// symbol_value); rsp_chan returns one item per instruction with both operand
// registers after the step and a status (ok, not a cons, heap full). Both
// use valid/ready; an item moves on a clock edge with valid and ready high.
// Timing: an instruction is taken only while the block is idle. After
// acceptance the block captures the operands, executes, makes a second
// register write for swap and for a cons that succeeds, then loads the
// result into the output register, and only then takes the next item.
// The steps follow from the registered reads of the register file and
// heap and the single register-file write port (swap and cons write twice).
// Stall: a pending result holds in the output register until taken; a new
// item may be accepted and worked on meanwhile, and the block waits only
// when it must load the next result into an occupied output register.
// Reset (synchronous, active high): all registers read as nil, the heap
// free pointer returns to zero and any pending result is dropped. Heap
// cells need no clearing since only allocated cells are ever read.
module linear_lisp_register_machine_top import llrm_pkg::*; (
   input logic        clock,
   input logic        reset,
   llrm_req_if.sink   req_chan,
   llrm_rsp_if.source rsp_chan
);

   cmd_type  cmd;
   stat_type stat;

   // Sequencer: accept, capture operands, execute, optional second write, deliver
   llrm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Register file, heap, free pointer and output register
   llrm_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .stat     (stat)
   );

   // An accepted item keeps the block busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted twice in a row");

   // Never overwrite a result that still waits to be taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !stat.out_busy)
      else $error("output register overwritten");

   // A response appears only after the sequencer loads one
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.out_load))
      else $error("response valid without load");

   // Heap writes happen only while an instruction is in flight
   a_heap_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.car_we || cmd.cdr_we) |-> !cmd.ready)
      else $error("heap written while idle");

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import llrm_pkg::*;

   // Reserved kinds: the block treats them as no-ops that still answer.
   localparam logic [KIND_W-1:0] KIND_RSVD_5 = 3'd5;
   localparam logic [KIND_W-1:0] KIND_RSVD_7 = 3'd7;

   // Abort after this many cycles in which neither channel moves an item.
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   // Quiet cycles to wait out after the last result, to catch stray items.
   localparam int unsigned SETTLE_CYCLES  = 20;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [REG_IDX_W-1:0] first_reg;
      logic [REG_IDX_W-1:0] second_reg;
      logic [HANDLE_W-1:0]  symbol_value;
   } instr_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] first_value;
      logic [HANDLE_W-1:0] second_value;
      logic [STATUS_W-1:0] status;
   } outcome_type;

   logic clock = 1'b0;
   logic reset;

   llrm_req_if req_chan ();
   llrm_rsp_if rsp_chan ();

   linear_lisp_register_machine_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // Instructions waiting to be driven, and outcomes waiting to come back.
   instr_type   program_queue[$];
   outcome_type predicted_outcomes[$];

   // Shadow machine state: register file, cell heap and bump pointer.
   logic [HANDLE_W-1:0] shadow_regs [REGISTER_COUNT];
   logic [HANDLE_W-1:0] shadow_car  [HEAP_CELLS];
   logic [HANDLE_W-1:0] shadow_cdr  [HEAP_CELLS];
   int unsigned         cells_allocated;

   // Conses handed to the driver so far; guides the choice of cell handles.
   int unsigned cons_issued;
   int unsigned error_count;

   instr_type   driven_instr;
   int unsigned send_hold, send_quiet;
   int unsigned take_hold, take_quiet;
   int unsigned stall_cycles;

   // Out-of-range registers read as nil and swallow writes.
   function automatic logic [HANDLE_W-1:0] read_reg(input logic [REG_IDX_W-1:0] idx);
      if (idx < REGISTER_COUNT) return shadow_regs[idx];
      return NIL;
   endfunction

   function automatic void write_reg(input logic [REG_IDX_W-1:0] idx,
                                     input logic [HANDLE_W-1:0]  value);
      if (idx < REGISTER_COUNT) shadow_regs[idx] = value;
   endfunction

   // Run one instruction on the shadow machine and return what the block must report.
   function automatic outcome_type execute_instruction(input instr_type ins);
      outcome_type         res;
      logic [HANDLE_W-1:0] va, vb, target;
      int unsigned         cell_idx;
      res.status = STAT_OK;
      case (ins.kind)
         KIND_SWAP: begin
            va = read_reg(ins.first_reg);
            vb = read_reg(ins.second_reg);
            write_reg(ins.first_reg, vb);
            write_reg(ins.second_reg, va);
         end
         KIND_ASSIGN: begin
            write_reg(ins.first_reg, ins.symbol_value);
         end
         KIND_CAR, KIND_CDR: begin
            target   = read_reg(ins.second_reg);
            cell_idx = 32'(target[HANDLE_W-2:0]);
            // nil, atoms and unallocated cells are all "not a cons"
            if (!target[HANDLE_W-1] || cell_idx >= cells_allocated) begin
               res.status = STAT_NOT_CONS;
            end else begin
               // load the field first, then store the old register value
               va = read_reg(ins.first_reg);
               if (ins.kind == KIND_CAR) begin
                  write_reg(ins.first_reg, shadow_car[cell_idx[HEAP_AW-1:0]]);
                  shadow_car[cell_idx[HEAP_AW-1:0]] = va;
               end else begin
                  write_reg(ins.first_reg, shadow_cdr[cell_idx[HEAP_AW-1:0]]);
                  shadow_cdr[cell_idx[HEAP_AW-1:0]] = va;
               end
            end
         end
         KIND_CONS: begin
            if (cells_allocated >= HEAP_CELLS) begin
               res.status = STAT_FULL;
            end else begin
               va = read_reg(ins.first_reg);
               vb = read_reg(ins.second_reg);
               shadow_car[cells_allocated[HEAP_AW-1:0]] = va;
               shadow_cdr[cells_allocated[HEAP_AW-1:0]] = vb;
               write_reg(ins.second_reg, CELL_BASE + HANDLE_W'(cells_allocated));
               cells_allocated++;
               // nil goes in last, so a doubled register ends as nil
               write_reg(ins.first_reg, NIL);
            end
         end
         default: ;
      endcase
      res.first_value  = read_reg(ins.first_reg);
      res.second_value = read_reg(ins.second_reg);
      return res;
   endfunction

   task automatic flag_error(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   // Per-item random wait, with occasional stretches of no waiting.
   function automatic int unsigned draw_wait(inout int unsigned quiet);
      if (quiet != 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) quiet = $urandom_range(10, 40);
      return $urandom_range(0, 7);
   endfunction

   // Mostly legal registers, now and then an index past the file.
   function automatic logic [REG_IDX_W-1:0] pick_reg();
      if ($urandom_range(0, 9) == 0)
         return REG_IDX_W'($urandom_range(0, (1 << REG_IDX_W) - 1));
      return REG_IDX_W'($urandom_range(0, REGISTER_COUNT - 1));
   endfunction

   function automatic logic [HANDLE_W-1:0] pick_handle();
      logic [HANDLE_W-1:0] h;
      int unsigned         top;
      top = (cons_issued < HEAP_CELLS) ? cons_issued : HEAP_CELLS;
      case ($urandom_range(0, 4))
         0:       h = NIL;
         1:       h = HANDLE_W'($urandom_range(1, CELL_BASE - 1));
         // near the allocated range, edge just past it included
         2:       h = CELL_BASE + HANDLE_W'($urandom_range(0, top));
         default: h = HANDLE_W'($urandom);
      endcase
      return h;
   endfunction

   function automatic logic [KIND_W-1:0] pick_kind();
      if ($urandom_range(0, 19) == 0)
         return KIND_W'($urandom_range(KIND_RSVD_5, KIND_RSVD_7));
      return KIND_W'($urandom_range(KIND_SWAP, KIND_CONS));
   endfunction

   function automatic logic [KIND_W-1:0] pick_field();
      return ($urandom_range(0, 1) == 0) ? KIND_CAR : KIND_CDR;
   endfunction

   task automatic push_instr(input logic [KIND_W-1:0]    kind,
                             input logic [REG_IDX_W-1:0] first_reg,
                             input logic [REG_IDX_W-1:0] second_reg,
                             input logic [HANDLE_W-1:0]  symbol_value);
      instr_type ins;
      ins.kind         = kind;
      ins.first_reg    = first_reg;
      ins.second_reg   = second_reg;
      ins.symbol_value = symbol_value;
      program_queue.push_back(ins);
      if (kind == KIND_CONS) cons_issued++;
   endtask

   // Mixed traffic: mostly "cons, then walk the new cell" sequences, the
   // rest single instructions with random content.
   task automatic random_mix(input int unsigned count);
      int unsigned          n;
      int unsigned          steps;
      logic [REG_IDX_W-1:0] holder, alias_reg;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 9) < 6) begin
            holder = pick_reg();
            push_instr(KIND_CONS, pick_reg(), holder, pick_handle());
            n++;
            steps = $urandom_range(1, 3);
            repeat (steps) begin
               if ($urandom_range(0, 3) == 0) begin
                  // move the cell handle elsewhere and follow it
                  alias_reg = pick_reg();
                  push_instr(KIND_SWAP, holder, alias_reg, pick_handle());
                  holder = alias_reg;
               end else begin
                  push_instr(pick_field(), pick_reg(), holder, pick_handle());
               end
               n++;
            end
         end else begin
            push_instr(pick_kind(), pick_reg(), pick_reg(), pick_handle());
            n++;
         end
      end
   endtask

   // Hold until every queued item is sent and every outcome is back.
   task automatic wait_until_settled();
      do @(negedge clock);
      while (program_queue.size() != 0 || req_chan.valid || predicted_outcomes.size() != 0);
   endtask

   // Driver: at each edge where the bus slot frees up, log the taken item
   // with the predictor, then either idle or present the next item.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_hold      <= 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) predicted_outcomes.push_back(execute_instruction(driven_instr));
         if (send_hold != 0) begin
            send_hold      <= send_hold - 1;
            req_chan.valid <= 1'b0;
         end else if (program_queue.size() != 0) begin
            driven_instr           = program_queue.pop_front();
            req_chan.kind         <= driven_instr.kind;
            req_chan.first_reg    <= driven_instr.first_reg;
            req_chan.second_reg   <= driven_instr.second_reg;
            req_chan.symbol_value <= driven_instr.symbol_value;
            req_chan.valid        <= 1'b1;
            // gap to leave after this item is taken
            send_hold             <= draw_wait(send_quiet);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Monitor: compare each taken result with the oldest prediction, then
   // keep ready high or drop it for a random wait drawn per result.
   always @(posedge clock) begin : take_results
      outcome_type want;
      int unsigned pause;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         take_hold      <= 0;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         if (predicted_outcomes.size() == 0) begin
            flag_error($sformatf("result with nothing outstanding: %h %h %h",
                                 rsp_chan.first_value, rsp_chan.second_value, rsp_chan.status));
         end else begin
            want = predicted_outcomes.pop_front();
            if (rsp_chan.first_value !== want.first_value)
               flag_error($sformatf("first_value got %h, want %h",
                                    rsp_chan.first_value, want.first_value));
            if (rsp_chan.second_value !== want.second_value)
               flag_error($sformatf("second_value got %h, want %h",
                                    rsp_chan.second_value, want.second_value));
            if (rsp_chan.status !== want.status)
               flag_error($sformatf("status got %0d, want %0d", rsp_chan.status, want.status));
         end
         pause = draw_wait(take_quiet);
         if (pause == 0) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b0;
            take_hold      <= pause - 1;
         end
      end else if (take_hold != 0) begin
         take_hold <= take_hold - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Watchdog: count cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired, %0d results outstanding", predicted_outcomes.size());
         $display("linear_lisp_register_machine_top test failed");
         $finish;
      end
   end

   initial begin
      // Drive every block input to a known value from time zero.
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.kind         = KIND_SWAP;
      req_chan.first_reg    = '0;
      req_chan.second_reg   = '0;
      req_chan.symbol_value = NIL;
      rsp_chan.ready        = 1'b0;
      for (int i = 0; i < REGISTER_COUNT; i++) shadow_regs[i] = NIL;
      cells_allocated = 0;
      cons_issued     = 0;
      error_count     = 0;
      stall_cycles    = 0;
      send_quiet      = 0;
      take_quiet      = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: field extremes, every defined kind, two reserved kinds, and the corner cases.
      push_instr(KIND_SWAP,   4'd0, 4'd9, NIL);           // nil against nil
      push_instr(KIND_ASSIGN, 4'd0, 4'd5, 16'h0001);      // smallest atom
      push_instr(KIND_ASSIGN, 4'd1, 4'd15, 16'h7FFF);     // largest atom
      push_instr(KIND_ASSIGN, 4'd9, 4'd0, 16'hFFFF);      // cell handle, never allocated
      push_instr(KIND_CAR,    4'd2, 4'd9, NIL);           // unallocated cell
      push_instr(KIND_CAR,    4'd2, 4'd0, NIL);           // atom
      push_instr(KIND_CDR,    4'd2, 4'd3, NIL);           // nil
      push_instr(KIND_SWAP,   4'd0, 4'd1, 16'hFFFF);
      push_instr(KIND_SWAP,   4'd1, 4'd1, NIL);           // same register
      push_instr(KIND_CONS,   4'd0, 4'd1, NIL);           // first cell
      push_instr(KIND_CAR,    4'd2, 4'd1, NIL);
      push_instr(KIND_CDR,    4'd3, 4'd1, NIL);
      push_instr(KIND_CAR,    4'd1, 4'd1, NIL);           // same register, cell stores itself
      push_instr(KIND_CONS,   4'd4, 4'd4, NIL);           // same register ends nil
      push_instr(KIND_CONS,   4'd5, 4'd6, NIL);
      push_instr(KIND_ASSIGN, 4'd8, 4'd2, CELL_BASE + 16'd3); // just past the bump pointer
      push_instr(KIND_CDR,    4'd0, 4'd8, NIL);
      push_instr(KIND_ASSIGN, 4'd7, 4'd3, CELL_BASE + 16'd2); // last allocated cell
      push_instr(KIND_CDR,    4'd0, 4'd7, NIL);
      push_instr(KIND_ASSIGN, 4'd15, 4'd7, 16'h1234);     // write to missing register dropped
      push_instr(KIND_SWAP,   4'd12, 4'd3, NIL);          // missing register reads nil
      push_instr(KIND_CAR,    4'd10, 4'd6, NIL);          // field loaded into nowhere
      push_instr(KIND_CDR,    4'd6, 4'd11, NIL);          // missing pointer register
      push_instr(KIND_RSVD_5, 4'd0, 4'd6, 16'hAAAA);
      push_instr(KIND_RSVD_7, 4'd14, 4'd6, 16'h5555);

      // Pause the sender until the directed part has fully drained.
      wait_until_settled();
      random_mix(450);
      wait_until_settled();
      random_mix(225);

      wait_until_settled();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (predicted_outcomes.size() != 0)
         flag_error($sformatf("%0d results never arrived", predicted_outcomes.size()));

      if (error_count == 0) begin
         $display("linear_lisp_register_machine_top test passed");
      end else begin
         $display("linear_lisp_register_machine_top test failed");
      end
      $finish;
   end

endmodule
